>>> src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst_n is low
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication, disabled while rst_n is low
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> src/ikvc_pkg.sv
// types and constants of the impedance velocity command block
// no dependencies; used by the interfaces, the step unit and the top level
package ikvc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int STEP_W     = 60;
    localparam int CNT_W      = 5;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DESIRED_FORCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_LIMIT = 3'd4;

    // register reset values
    localparam logic [15:0] DESIRED_FORCE_RST  = 16'd0;
    localparam logic [23:0] FORCE_GAIN_RST     = 24'd1310707;
    localparam logic [23:0] PROCESS_NOISE_RST  = 24'd6554;
    localparam logic [23:0] MEASURE_NOISE_RST  = 24'd65536;
    localparam logic [30:0] VELOCITY_LIMIT_RST = 31'd10000;

    // 1.0 in the covariance and gain formats
    localparam logic [23:0] P_ONE = 24'd65536;
    localparam logic [16:0] K_ONE = 17'd65536;

    // operation codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // first counter values of the divide and the shift-add multiply; both count down to 0
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd15;
    localparam logic [CNT_W-1:0] MAC_LAST = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV0,
        S_DIV,
        S_MAC,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic sub;
        logic add_en;
    } t_step_ctl;

endpackage

>>> src/ikvc_if.sv
// valid/ready channels of the impedance velocity command block
// depends on ikvc_pkg for the configuration widths
interface ikvc_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] torque_sample;

    modport source (output valid, operation, torque_sample, input ready);
    modport sink   (input valid, operation, torque_sample, output ready);
endinterface

interface ikvc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] velocity_cmd;
    logic               saturated;

    modport source (output valid, velocity_cmd, saturated, input ready);
    modport sink   (input valid, velocity_cmd, saturated, output ready);
endinterface

interface ikvc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ikvc_pkg::CFG_IDX_W-1:0]    index;
    logic [ikvc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/ikvc_step_unit.sv
// shared add/subtract unit stepped by the sequencer
// used for both the restoring divide and the shift-add multiply; depends on ikvc_pkg
module ikvc_step_unit (
    input  ikvc_pkg::t_step_ctl              i_ctl,
    input  logic [ikvc_pkg::STEP_W-1:0]      i_a,
    input  logic [ikvc_pkg::STEP_W-1:0]      i_b,
    output logic [ikvc_pkg::STEP_W-1:0]      o_sum
);

    logic [ikvc_pkg::STEP_W-1:0] w_b;

    assign w_b = i_ctl.add_en ? i_b : '0;

    always_comb begin
        if (i_ctl.sub) begin
            o_sum = i_a - w_b;
        end else begin
            o_sum = i_a + w_b;
        end
    end

endmodule

>>> src/impedance_kalman_velocity_command.sv
// update item: prep, divide, multiply, update, load; no divide when the gain is 0 or 1.0
// clear item: straight to the output load; input ready again right after the load
// one item at a time: 16-step divide, 17-step multiply on one adder
// a finished result waits in the output register while the next item is taken
// sync reset: registers to defaults, covariance 1.0, estimate 0, output empty
// depends on ikvc_pkg, ikvc_if and ikvc_step_unit
module impedance_kalman_velocity_command (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ikvc_cfg_if.sink    i_cfg,
    ikvc_in_if.sink     i_in,
    ikvc_out_if.source  o_out
);

    // configuration
    logic signed [15:0] r_df;
    logic [23:0]        r_gain;
    logic [23:0]        r_q;
    logic [23:0]        r_r;
    logic [30:0]        r_vlim;

    // filter state and work registers
    ikvc_pkg::t_state   r_state, n_state;
    logic [23:0]        r_p;
    logic signed [47:0] r_x;
    logic signed [16:0] r_err;
    logic signed [40:0] r_z;
    logic [23:0]        r_pp;
    logic [24:0]        r_den;
    logic [24:0]        r_rem;
    logic [16:0]        r_k;
    logic [41:0]        r_mag;
    logic               r_neg;
    logic [58:0]        r_acc;
    logic [ikvc_pkg::CNT_W-1:0] r_cnt;

    // output register
    logic               r_ovalid;
    logic signed [31:0] r_ovel;
    logic               r_osat;

    logic                          w_ready;
    logic                          w_load_out;
    ikvc_pkg::t_step_ctl           w_ctl;
    logic [ikvc_pkg::STEP_W-1:0]   w_a, w_b, w_sum;
    logic                          w_accept;

    logic signed [41:0] w_zprod;
    logic [24:0]        w_pp_sum;
    logic [23:0]        w_pp_sat;
    logic signed [48:0] w_diff;
    logic [48:0]        w_diff_abs;
    logic [42:0]        w_corr;
    logic [40:0]        w_pprod;
    logic signed [47:0] w_lim;
    logic [47:0]        w_xabs;
    logic [31:0]        w_vmag;
    logic signed [31:0] w_vel;
    logic               w_sat;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_ready;
    assign w_accept    = i_in.valid && w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_df   <= ikvc_pkg::DESIRED_FORCE_RST;
            r_gain <= ikvc_pkg::FORCE_GAIN_RST;
            r_q    <= ikvc_pkg::PROCESS_NOISE_RST;
            r_r    <= ikvc_pkg::MEASURE_NOISE_RST;
            r_vlim <= ikvc_pkg::VELOCITY_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ikvc_pkg::CFG_DESIRED_FORCE:  r_df   <= i_cfg.data[15:0];
                ikvc_pkg::CFG_FORCE_GAIN:     r_gain <= i_cfg.data[23:0];
                ikvc_pkg::CFG_PROCESS_NOISE:  r_q    <= i_cfg.data[23:0];
                ikvc_pkg::CFG_MEASURE_NOISE:  r_r    <= i_cfg.data[23:0];
                ikvc_pkg::CFG_VELOCITY_LIMIT: r_vlim <= i_cfg.data[30:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ikvc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.operation == ikvc_pkg::OP_CLEAR) ?
                              ikvc_pkg::S_DONE : ikvc_pkg::S_PREP;
                end
            end
            ikvc_pkg::S_PREP: n_state = ikvc_pkg::S_DIV0;
            ikvc_pkg::S_DIV0: begin
                if (r_den != '0 && {1'b0, r_pp} < r_den) begin
                    n_state = ikvc_pkg::S_DIV;
                end else begin
                    n_state = ikvc_pkg::S_MAC;
                end
            end
            ikvc_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ikvc_pkg::S_MAC;
                end
            end
            ikvc_pkg::S_MAC: begin
                if (r_cnt == '0) begin
                    n_state = ikvc_pkg::S_UPD;
                end
            end
            ikvc_pkg::S_UPD: n_state = ikvc_pkg::S_DONE;
            ikvc_pkg::S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = ikvc_pkg::S_IDLE;
                end
            end
            default: n_state = ikvc_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ready    = 1'b0;
        w_load_out = 1'b0;
        w_ctl      = '0;
        w_a        = '0;
        w_b        = '0;
        case (r_state)
            ikvc_pkg::S_IDLE: w_ready = 1'b1;
            ikvc_pkg::S_DIV: begin
                w_ctl.sub    = 1'b1;
                w_ctl.add_en = 1'b1;
                w_a = {{(ikvc_pkg::STEP_W-26){1'b0}}, r_rem, 1'b0};
                w_b = {{(ikvc_pkg::STEP_W-25){1'b0}}, r_den};
            end
            ikvc_pkg::S_MAC: begin
                w_ctl.add_en = r_k[r_cnt];
                w_a = {r_acc, 1'b0};
                w_b = {{(ikvc_pkg::STEP_W-42){1'b0}}, r_mag};
            end
            ikvc_pkg::S_DONE: w_load_out = !r_ovalid || o_out.ready;
            default: ;
        endcase
    end

    ikvc_step_unit u_step (
        .i_ctl (w_ctl),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_sum (w_sum)
    );

    // datapath arithmetic around the shared unit
    assign w_zprod    = r_err * $signed({1'b0, r_gain});
    assign w_pp_sum   = {1'b0, r_p} + {1'b0, r_q};
    assign w_pp_sat   = w_pp_sum[24] ? 24'hFF_FFFF : w_pp_sum[23:0];
    assign w_diff     = {{8{r_z[40]}}, r_z} - {r_x[47], r_x};
    assign w_diff_abs = w_diff[48] ? 49'(-w_diff) : w_diff;
    assign w_corr     = r_acc[58:16];
    assign w_pprod    = (ikvc_pkg::K_ONE - r_k) * r_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ikvc_pkg::S_IDLE;
            r_p     <= ikvc_pkg::P_ONE;
            r_x     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ikvc_pkg::S_IDLE: begin
                    if (w_accept) begin
                        if (i_in.operation == ikvc_pkg::OP_CLEAR) begin
                            r_p <= ikvc_pkg::P_ONE;
                            r_x <= '0;
                        end
                    end
                end
                ikvc_pkg::S_DIV0: begin
                    // trivial gains skip the divide
                    r_cnt <= (r_den != '0 && {1'b0, r_pp} < r_den) ?
                             ikvc_pkg::DIV_LAST : ikvc_pkg::MAC_LAST;
                end
                ikvc_pkg::S_DIV: begin
                    r_cnt <= (r_cnt == '0) ? ikvc_pkg::MAC_LAST : r_cnt - 1'b1;
                end
                ikvc_pkg::S_MAC: r_cnt <= r_cnt - 1'b1;
                ikvc_pkg::S_UPD: begin
                    // correction is truncated toward zero via sign and magnitude
                    if (r_neg) begin
                        r_x <= r_x - $signed({5'b0, w_corr});
                    end else begin
                        r_x <= r_x + $signed({5'b0, w_corr});
                    end
                    r_p <= w_pprod[39:16];
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ikvc_pkg::S_IDLE: begin
                r_err <= $signed({r_df[15], r_df}) -
                         $signed({i_in.torque_sample[15], i_in.torque_sample});
            end
            ikvc_pkg::S_PREP: begin
                r_z   <= w_zprod[40:0];
                r_pp  <= w_pp_sat;
                r_den <= {1'b0, w_pp_sat} + {1'b0, r_r};
            end
            ikvc_pkg::S_DIV0: begin
                r_neg <= w_diff[48];
                r_mag <= w_diff_abs[41:0];
                r_acc <= '0;
                r_rem <= {1'b0, r_pp};
                if (r_den == '0) begin
                    r_k <= '0;
                end else if ({1'b0, r_pp} >= r_den) begin
                    r_k <= ikvc_pkg::K_ONE;
                end else begin
                    r_k <= '0;
                end
            end
            ikvc_pkg::S_DIV: begin
                // restoring step: keep the difference when it did not go negative
                if (!w_sum[ikvc_pkg::STEP_W-1]) begin
                    r_rem <= w_sum[24:0];
                    r_k   <= {r_k[15:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[23:0], 1'b0};
                    r_k   <= {r_k[15:0], 1'b0};
                end
            end
            ikvc_pkg::S_MAC: r_acc <= w_sum[58:0];
            default: ;
        endcase
    end

    // clamp and truncate the estimate
    assign w_lim  = $signed({1'b0, r_vlim, 16'h0000});
    assign w_xabs = r_x[47] ? 48'(-r_x) : r_x;
    assign w_vmag = w_xabs[47:16];

    always_comb begin
        w_sat = 1'b0;
        if (r_x > w_lim) begin
            w_sat = 1'b1;
            w_vel = $signed({1'b0, r_vlim});
        end else if (r_x < -w_lim) begin
            w_sat = 1'b1;
            w_vel = -$signed({1'b0, r_vlim});
        end else begin
            w_vel = r_x[47] ? -$signed(w_vmag) : $signed(w_vmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_ovel <= w_vel;
            r_osat <= w_sat;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.velocity_cmd = r_ovel;
    assign o_out.saturated    = r_osat;

endmodule

>>> src/ikvc_checker.sv
// port-level checks of the impedance velocity command block, bound to the top level
// depends on assert_macros.svh and impedance_kalman_velocity_command
`include "assert_macros.svh"

module ikvc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_velocity,
    input logic        i_out_saturated,
    input logic        i_cfg_ready
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_velocity, i_out_saturated}))

    // one item at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // reset empties the output register
    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !i_out_valid)

    // configuration writes are never stalled
    `ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, 1'b1, i_cfg_ready)

endmodule

bind impedance_kalman_velocity_command ikvc_checker u_ikvc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_velocity  (o_out.velocity_cmd),
    .i_out_saturated (o_out.saturated),
    .i_cfg_ready     (i_cfg.ready)
);

>>> sim/impedance_kalman_velocity_command_test.sv
`timescale 1ns / 100ps
// self-checking bench for the impedance velocity command block with its kalman smoother
// depends on ikvc_pkg, the ikvc channel interfaces and impedance_kalman_velocity_command
module impedance_kalman_velocity_command_test;

    localparam int CFG_IDX_W    = ikvc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = ikvc_pkg::CFG_DATA_W;
    localparam int RANDOM_ITEMS = 1530;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int HOLD_LEN     = 300;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int N_ROWS       = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;

    typedef enum logic [1:0] {
        SETUP_KEEP,
        SETUP_UNIT,
        SETUP_WIDE,
        SETUP_ZERO_GAIN
    } t_setup;

    typedef struct packed {
        logic signed [31:0] vel;
        logic               sat;
    } t_vel_result;

    typedef struct packed {
        t_setup             setup;
        logic               op;
        logic signed [15:0] tq;
        logic               typed;
        logic signed [31:0] vel;
        logic               sat;
    } t_table_row;

    // typed rows: clear, zero error, reset-gain extremes, unit gain with noise off,
    // zero divisor, covariance overflow with zero limit, zero gain
    t_table_row directed_rows [N_ROWS] = '{
        '{SETUP_KEEP,      ikvc_pkg::OP_CLEAR,   16'sd0,      1'b1, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE,  16'sd0,      1'b1, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE, -16'sd32768,  1'b1, 32'sd10000,  1'b1},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE,  16'sd32767,  1'b1, -32'sd10000, 1'b1},
        '{SETUP_KEEP,      ikvc_pkg::OP_CLEAR,   16'sd32767,  1'b1, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE,  16'sd1,      1'b0, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE, -16'sd1,      1'b0, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE,  16'sd500,    1'b0, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE, -16'sd500,    1'b0, 32'sd0,      1'b0},
        '{SETUP_UNIT,      ikvc_pkg::OP_CLEAR,  -16'sd32768,  1'b1, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE, -16'sd32768,  1'b1, 32'sd32768,  1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE,  16'sd32767,  1'b1, 32'sd32768,  1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_CLEAR,   16'sd0,      1'b1, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE,  16'sd12345,  1'b1, -32'sd12345, 1'b0},
        '{SETUP_WIDE,      ikvc_pkg::OP_UPDATE,  16'sd32767,  1'b1, 32'sd0,      1'b1},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE, -16'sd32768,  1'b0, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE,  16'sd0,      1'b0, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_CLEAR,  -16'sd1,      1'b1, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE, -16'sd32768,  1'b1, 32'sd0,      1'b0},
        '{SETUP_ZERO_GAIN, ikvc_pkg::OP_UPDATE, -16'sd32768,  1'b1, 32'sd0,      1'b0},
        '{SETUP_KEEP,      ikvc_pkg::OP_UPDATE,  16'sd32767,  1'b0, 32'sd0,      1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ikvc_cfg_if cfg_ch ();
    ikvc_in_if  in_ch ();
    ikvc_out_if out_ch ();

    impedance_kalman_velocity_command uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // register copies and filter state of the predictor
    logic signed [15:0] cfg_desired;
    logic [23:0]        cfg_gain;
    logic [23:0]        cfg_q;
    logic [23:0]        cfg_r;
    logic [30:0]        cfg_limit;
    logic [23:0]        pred_cov;
    longint             pred_est;

    t_vel_result vel_expected [$];
    t_vel_result got;
    t_vel_result want;

    int  fail_count   = 0;
    int  items_sent   = 0;
    int  clears_sent  = 0;
    int  results_seen = 0;
    int  sat_seen     = 0;
    int  cfg_writes   = 0;
    int  cycle_count  = 0;
    int  burst_left   = 0;
    bit  steady       = 1'b0;
    bit  hold_done    = 1'b0;

    function automatic void kalman_predict(input logic op, input logic signed [15:0] tq,
                                           output logic signed [31:0] vel, output logic sat);
        longint          err;
        longint          z;
        longint          diff;
        longint          lim;
        longint          k;
        longint unsigned pp;
        longint unsigned den;
        vel = '0;
        sat = 1'b0;
        if (op == ikvc_pkg::OP_CLEAR) begin
            pred_cov = ikvc_pkg::P_ONE;
            pred_est = 0;
            return;
        end
        err = longint'(cfg_desired) - longint'(tq);
        z   = err * longint'(cfg_gain);
        pp  = 64'(pred_cov) + 64'(cfg_q);
        if (pp > 64'hFF_FFFF) pp = 64'hFF_FFFF;
        den = pp + 64'(cfg_r);
        k   = (den == 0) ? 0 : longint'((pp << 16) / den);
        diff = z - pred_est;
        // signed divide truncates toward zero
        pred_est = pred_est + (diff * k) / longint'(65536);
        pred_cov = 24'(((64'd65536 - 64'(k)) * pp) >> 16);
        lim = longint'(cfg_limit) * longint'(65536);
        if (pred_est > lim) begin
            vel = 32'(cfg_limit);
            sat = 1'b1;
        end else if (pred_est < -lim) begin
            vel = -32'(cfg_limit);
            sat = 1'b1;
        end else begin
            vel = 32'(pred_est / longint'(65536));
        end
    endfunction

    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            ikvc_pkg::CFG_DESIRED_FORCE:  cfg_desired = data[15:0];
            ikvc_pkg::CFG_FORCE_GAIN:     cfg_gain    = data[23:0];
            ikvc_pkg::CFG_PROCESS_NOISE:  cfg_q       = data[23:0];
            ikvc_pkg::CFG_MEASURE_NOISE:  cfg_r       = data[23:0];
            ikvc_pkg::CFG_VELOCITY_LIMIT: cfg_limit   = data[30:0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] random_torque();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2, 3: return cfg_desired + 16'($urandom_range(0, 64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic op, input logic signed [15:0] tq, input logic typed,
                             input logic signed [31:0] tvel, input logic tsat);
        logic signed [31:0] pvel;
        logic               psat;
        int                 gap;
        if (!steady && burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.torque_sample <= tq;
        do @(posedge i_clk); while (!in_ch.ready);
        kalman_predict(op, tq, pvel, psat);
        if (typed) begin
            pvel = tvel;
            psat = tsat;
        end
        vel_expected.push_back('{vel: pvel, sat: psat});
        items_sent++;
        if (op == ikvc_pkg::OP_CLEAR) clears_sent++;
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
    endtask

    // leaves cfg valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        shadow_write(idx, data);
        cfg_writes++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (vel_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_setup(input t_setup s);
        if (s == SETUP_KEEP) return;
        wait_idle();
        case (s)
            SETUP_UNIT: begin
                write_reg(ikvc_pkg::CFG_DESIRED_FORCE, CFG_DATA_W'(16'h0000));
                write_reg(ikvc_pkg::CFG_FORCE_GAIN, CFG_DATA_W'(ikvc_pkg::P_ONE));
                write_reg(ikvc_pkg::CFG_PROCESS_NOISE, '0);
                write_reg(ikvc_pkg::CFG_MEASURE_NOISE, '0);
                write_reg(ikvc_pkg::CFG_VELOCITY_LIMIT, CFG_DATA_W'(31'h7FFF_FFFF));
                write_reg(CFG_IDX_MAX, '1);
            end
            SETUP_WIDE: begin
                write_reg(ikvc_pkg::CFG_DESIRED_FORCE, CFG_DATA_W'(16'h8000));
                write_reg(ikvc_pkg::CFG_FORCE_GAIN, CFG_DATA_W'(24'hFF_FFFF));
                write_reg(ikvc_pkg::CFG_PROCESS_NOISE, CFG_DATA_W'(24'hFF_FFFF));
                write_reg(ikvc_pkg::CFG_MEASURE_NOISE, CFG_DATA_W'(24'hFF_FFFF));
                write_reg(ikvc_pkg::CFG_VELOCITY_LIMIT, '0);
            end
            default: begin
                write_reg(ikvc_pkg::CFG_DESIRED_FORCE, CFG_DATA_W'(16'h7FFF));
                write_reg(ikvc_pkg::CFG_FORCE_GAIN, '0);
                write_reg(ikvc_pkg::CFG_PROCESS_NOISE, '0);
                write_reg(ikvc_pkg::CFG_MEASURE_NOISE, CFG_DATA_W'(1));
                write_reg(ikvc_pkg::CFG_VELOCITY_LIMIT, CFG_DATA_W'(5));
            end
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_random_config();
        int                    first;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [23:0]           v24;
        wait_idle();
        // writes to unused indexes must be ignored
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(ikvc_pkg::CFG_VELOCITY_LIMIT + 1,
                                                CFG_IDX_MAX)),
                      CFG_DATA_W'($urandom));
        first = $urandom_range(0, ikvc_pkg::CFG_VELOCITY_LIMIT);
        for (int i = 0; i <= ikvc_pkg::CFG_VELOCITY_LIMIT; i++) begin
            idx = CFG_IDX_W'((first + i) % (ikvc_pkg::CFG_VELOCITY_LIMIT + 1));
            case ($urandom_range(0, 5))
                0: v24 = '0;
                1: v24 = 24'hFF_FFFF;
                2: v24 = 24'($urandom);
                3: v24 = ikvc_pkg::P_ONE;
                default: v24 = 24'($urandom_range(0, 200000));
            endcase
            // upper bits beyond the register width carry junk
            val = {7'($urandom), v24};
            case (idx)
                ikvc_pkg::CFG_DESIRED_FORCE: begin
                    case ($urandom_range(0, 3))
                        0: val[15:0] = 16'h8000;
                        1: val[15:0] = 16'h7FFF;
                        default: val[15:0] = 16'($urandom);
                    endcase
                end
                ikvc_pkg::CFG_FORCE_GAIN: begin
                    if ($urandom_range(0, 2) != 0) val[23:0] = 24'($urandom_range(0, 3000000));
                end
                ikvc_pkg::CFG_VELOCITY_LIMIT: begin
                    case ($urandom_range(0, 4))
                        0: val = '0;
                        1: val = 31'h7FFF_FFFF;
                        2: val = 31'($urandom);
                        default: val = 31'($urandom_range(0, 50000));
                    endcase
                end
                default: ;
            endcase
            write_reg(idx, val);
        end
        cfg_ch.valid <= 1'b0;
        steady = ($urandom_range(0, 3) == 0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.vel = out_ch.velocity_cmd;
            got.sat = out_ch.saturated;
            results_seen++;
            if (got.sat === 1'b1) sat_seen++;
            if (vel_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result vel=%0d sat=%0b", $realtime, got.vel,
                             got.sat);
            end else begin
                want = vel_expected.pop_front();
                if (got.vel !== want.vel || got.sat !== want.sat) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result %0d: vel exp %0d got %0d, sat exp %0b got %0b",
                                 $realtime, results_seen, want.vel, got.vel, want.sat,
                                 got.sat);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     vel_expected.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: changing stall patterns plus one long hold that backs up the input
    initial begin
        int mode;
        int mode_left;
        int hold_cycles;
        mode = 0;
        mode_left = 0;
        hold_cycles = 0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                out_ch.ready <= 1'b0;
                hold_cycles++;
                if (hold_cycles >= HOLD_LEN) hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 7) == 0);
                    default: out_ch.ready <= (mode_left % 5 != 0);
                endcase
            end
        end
    end

    initial begin
        logic               op;
        logic signed [15:0] tq;
        int                 phase_left;
        int                 random_sent;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.operation     = ikvc_pkg::OP_UPDATE;
        in_ch.torque_sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = ikvc_pkg::CFG_DESIRED_FORCE;
        cfg_ch.data  = '0;
        cfg_desired = ikvc_pkg::DESIRED_FORCE_RST;
        cfg_gain    = ikvc_pkg::FORCE_GAIN_RST;
        cfg_q       = ikvc_pkg::PROCESS_NOISE_RST;
        cfg_r       = ikvc_pkg::MEASURE_NOISE_RST;
        cfg_limit   = ikvc_pkg::VELOCITY_LIMIT_RST;
        pred_cov    = ikvc_pkg::P_ONE;
        pred_est    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            apply_setup(directed_rows[i].setup);
            send_item(directed_rows[i].op, directed_rows[i].tq, directed_rows[i].typed,
                      directed_rows[i].vel, directed_rows[i].sat);
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            write_random_config();
            phase_left = $urandom_range(100, 250);
            while (phase_left > 0 && random_sent < RANDOM_ITEMS) begin
                op = ($urandom_range(0, 24) == 0) ? ikvc_pkg::OP_CLEAR : ikvc_pkg::OP_UPDATE;
                tq = random_torque();
                send_item(op, tq, 1'b0, '0, 1'b0);
                phase_left--;
                random_sent++;
            end
        end

        in_ch.valid <= 1'b0;
        while (vel_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items (%0d clears), %0d results, %0d saturated, %0d register writes",
                 items_sent, clears_sent, results_seen, sat_seen, cfg_writes);
        $display("%0d mismatches over %0d cycles", fail_count, cycle_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
